// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the texture sine displacement core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, including during reset.
`define ASSERT_NOW(label, clk_sig, prop) \
  label: assert property (@(posedge clk_sig) prop) \
    else $error("uvsd assertion failed");

// Property checked only while reset is low.
`define ASSERT_RST(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("uvsd assertion failed");

`endif

// File: rtl/core/uvsd_pkg.sv
// ----------------------------------------------------------------------------
// uvsd_pkg
// Types, constants and the sine table generator of the texture sine core.
// ----------------------------------------------------------------------------
`default_nettype none

package uvsd_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned DELTA_W = 10;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Item kinds.
  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_AMP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_AMP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PER_VERTEX = 2'd3;

  localparam logic [REG_W-1:0] X_AMP_RESET  = 16'd410;
  localparam logic [REG_W-1:0] Y_AMP_RESET  = 16'd410;
  localparam logic [REG_W-1:0] RATE_RESET   = 16'd10;
  localparam logic [REG_W-1:0] PER_VERTEX_RESET = 16'd0;

  // One turn minus two radians (20861 units), so adding it subtracts two radians.
  localparam logic [PHASE_W-1:0] PHASE_OFFSET = 16'd44675;
  // 0.5 in Q2.14.
  localparam logic signed [COORD_W:0] HALF_Q14 = 17'sd8192;
  // pi/2 in Q30.
  localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [REG_W-1:0] x_amp;
    logic signed [REG_W-1:0] y_amp;
    logic [REG_W-1:0]        rate;
    logic [REG_W-1:0]        per_vertex;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic [PHASE_W-1:0]        phase;
  } vert_t;

  // Quarter-wave sine entry k of a table with 2^bits steps, Q1.15, from a
  // truncated Taylor series in Q30. Only ever called with constant arguments.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] r;
    x    = (PIHALF_Q30 * 64'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + term;
    r = (acc + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/uvsd_front.sv
// ----------------------------------------------------------------------------
// uvsd_front
// Accepts items, advances the time phase on ticks and queues vertex items.
// ----------------------------------------------------------------------------
`default_nettype none

module uvsd_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 mode,
  input  wire logic [uvsd_pkg::IDX_W-1:0]           vertex_index,
  input  wire logic signed [uvsd_pkg::COORD_W-1:0]  base_u,
  input  wire logic signed [uvsd_pkg::COORD_W-1:0]  base_v,
  input  wire logic [uvsd_pkg::DELTA_W-1:0]         delta_ms,
  input  wire uvsd_pkg::cfg_t                       cfg,
  input  wire logic                                 full,
  output logic                                      push,
  output uvsd_pkg::vert_t                           push_item
);

  logic [uvsd_pkg::PHASE_W-1:0] time_phase;
  logic [uvsd_pkg::DELTA_W+uvsd_pkg::REG_W-1:0] advance;
  logic accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign advance  = (uvsd_pkg::DELTA_W+uvsd_pkg::REG_W)'(delta_ms) *
                    (uvsd_pkg::DELTA_W+uvsd_pkg::REG_W)'(cfg.rate);

  // A vertex item carries the phase as it stands at its place in the stream.
  assign push            = accept && (mode == uvsd_pkg::MODE_VERTEX);
  assign push_item.index = vertex_index;
  assign push_item.u     = base_u;
  assign push_item.v     = base_v;
  assign push_item.phase = time_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_phase <= '0;
    end else if (accept && (mode == uvsd_pkg::MODE_TICK)) begin
      time_phase <= time_phase + advance[uvsd_pkg::PHASE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/uvsd_queue.sv
// ----------------------------------------------------------------------------
// uvsd_queue
// Short register queue of vertex items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module uvsd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire uvsd_pkg::vert_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output uvsd_pkg::vert_t      head
);

  localparam int unsigned DEPTH = uvsd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  uvsd_pkg::vert_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_RST(a_count_bound, clk, rst, count <= DEPTH_C)
  `ASSERT_RST(a_no_push_full, clk, rst, !(push && full))
  `ASSERT_RST(a_no_pop_empty, clk, rst, !(pop && empty))

endmodule

`default_nettype wire

// File: rtl/core/uvsd_back.sv
// ----------------------------------------------------------------------------
// uvsd_back
// Seven-stage pipeline: index wrap, phase, sine lookup, gain, trig, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module uvsd_back #(
  parameter int unsigned MAX_VERTICES    = 4096,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire uvsd_pkg::cfg_t                       cfg,
  input  wire logic                                 empty,
  input  wire uvsd_pkg::vert_t                      head,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [uvsd_pkg::IDX_W-1:0]                out_index,
  output logic signed [uvsd_pkg::COORD_W-1:0]       out_u,
  output logic signed [uvsd_pkg::COORD_W-1:0]       out_v
);

  localparam int unsigned IDX_W   = uvsd_pkg::IDX_W;
  localparam int unsigned PHASE_W = uvsd_pkg::PHASE_W;
  localparam int unsigned REG_W   = uvsd_pkg::REG_W;
  localparam int unsigned CW      = uvsd_pkg::COORD_W;

  // Index modulo the vertex count by a reciprocal multiply. With a 12-bit
  // index the scaled reciprocal error stays below one count, so the quotient
  // is exact.
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RPROD_W     = IDX_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / MAX_VERTICES + 1);
  localparam int unsigned MAXV_W = 17;
  localparam int unsigned QM_W   = IDX_W + MAXV_W;
  localparam logic [MAXV_W-1:0] MAXV = MAXV_W'(MAX_VERTICES);

  localparam int unsigned QSTEPS = 1 << SINE_TABLE_BITS;
  localparam int unsigned ADDR_W = SINE_TABLE_BITS + 1;
  localparam logic [ADDR_W-1:0] QTOP = ADDR_W'(QSTEPS);

  localparam int unsigned DIFF_W = CW + 1;
  localparam int unsigned GP_W   = DIFF_W + REG_W;
  localparam int unsigned TP_W   = GP_W + CW;
  localparam int unsigned RSH    = 27;
  localparam int unsigned DEL_W  = TP_W - RSH;
  localparam int unsigned SUM_W  = DEL_W + 1;
  localparam logic signed [TP_W-1:0] RND = TP_W'(64'd1 << (RSH - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

  // Quarter-wave table, fixed at elaboration.
  logic [15:0] sine_rom [QSTEPS+1];
  for (genvar k = 0; k <= QSTEPS; k++) begin : g_rom
    assign sine_rom[k] = uvsd_pkg::sine_entry(k, SINE_TABLE_BITS);
  end

  logic advance;

  logic            s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  uvsd_pkg::vert_t s1_item, s2_item, s3_item, s4_item, s5_item, s6_item;
  logic [IDX_W-1:0]   s1_q;
  logic [IDX_W-1:0]   s2_idx;
  logic [PHASE_W-1:0] s3_phase;
  logic signed [CW-1:0]     s4_sin, s4_cos;
  logic signed [DIFF_W-1:0] s4_diff_u, s4_diff_v;
  logic signed [CW-1:0]     s5_sin, s5_cos;
  logic signed [GP_W-1:0]   s5_pu, s5_pv;
  logic signed [TP_W-1:0]   s6_wu, s6_wv;

  logic [RPROD_W-1:0]        rprod;
  logic [QM_W-1:0]           qm;
  logic [IDX_W+REG_W-1:0]    vstep;
  logic [1:0]                sin_quad, cos_quad;
  logic [SINE_TABLE_BITS-1:0] pos;
  logic [ADDR_W-1:0]         sin_addr, cos_addr;
  logic [15:0]               sin_mag, cos_mag;
  logic signed [TP_W-1:0]    ru, rv;
  logic signed [SUM_W-1:0]   sum_u, sum_v;
  logic signed [CW-1:0]      sat_u, sat_v;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  assign rprod = RPROD_W'(head.index) * RPROD_W'(RECIP);
  assign qm    = QM_W'(s1_q) * QM_W'(MAXV);
  assign vstep = (IDX_W+REG_W)'(s2_idx) * (IDX_W+REG_W)'(cfg.per_vertex);

  // Cosine is the sine a quarter turn on: same position, next quadrant.
  always_comb begin
    sin_quad = s3_phase[PHASE_W-1 -: 2];
    cos_quad = sin_quad + 2'd1;
    pos      = s3_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    sin_addr = sin_quad[0] ? (QTOP - {1'b0, pos}) : {1'b0, pos};
    cos_addr = cos_quad[0] ? (QTOP - {1'b0, pos}) : {1'b0, pos};
    sin_mag  = sine_rom[sin_addr];
    cos_mag  = sine_rom[cos_addr];
  end

  // Round half up, add the base coordinate, then saturate to Q2.14.
  always_comb begin
    ru    = s6_wu + RND;
    rv    = s6_wv + RND;
    sum_u = SUM_W'(s6_item.u) + SUM_W'($signed(ru[TP_W-1:RSH]));
    sum_v = SUM_W'(s6_item.v) + SUM_W'($signed(rv[TP_W-1:RSH]));
    if (sum_u > SAT_HI) begin
      sat_u = CW'(SAT_HI);
    end else if (sum_u < SAT_LO) begin
      sat_u = CW'(SAT_LO);
    end else begin
      sat_u = CW'(sum_u);
    end
    if (sum_v > SAT_HI) begin
      sat_v = CW'(SAT_HI);
    end else if (sum_v < SAT_LO) begin
      sat_v = CW'(SAT_LO);
    end else begin
      sat_v = CW'(sum_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      out_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item   <= head;
      s1_q      <= rprod[RPROD_W-1:RECIP_SHIFT];

      s2_item   <= s1_item;
      s2_idx    <= s1_item.index - qm[IDX_W-1:0];

      s3_item   <= s2_item;
      s3_phase  <= s2_item.phase + vstep[PHASE_W-1:0] + uvsd_pkg::PHASE_OFFSET;

      s4_item   <= s3_item;
      s4_sin    <= sin_quad[1] ? -CW'(sin_mag) : CW'(sin_mag);
      s4_cos    <= cos_quad[1] ? -CW'(cos_mag) : CW'(cos_mag);
      s4_diff_u <= uvsd_pkg::HALF_Q14 - DIFF_W'(s3_item.u);
      s4_diff_v <= uvsd_pkg::HALF_Q14 - DIFF_W'(s3_item.v);

      s5_item   <= s4_item;
      s5_sin    <= s4_sin;
      s5_cos    <= s4_cos;
      s5_pu     <= GP_W'(s4_diff_u) * GP_W'(cfg.x_amp);
      s5_pv     <= GP_W'(s4_diff_v) * GP_W'(cfg.y_amp);

      s6_item   <= s5_item;
      s6_wu     <= TP_W'(s5_pu) * TP_W'(s5_cos);
      s6_wv     <= TP_W'(s5_pv) * TP_W'(s5_sin);

      out_index <= s6_item.index;
      out_u     <= sat_u;
      out_v     <= sat_v;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/uv_sine_displacement.sv
// Path: an accepted vertex item is written to the queue, then passes the seven back stages.
// Throughput: one item per cycle while the queue is not full, ticks and vertices alike; a tick gives no result.
// The rate is set by the seven-stage back pipeline, which advances whenever its
// output register is empty or being taken; a four-item queue absorbs stalls.
// Reset (synchronous) zeroes the time phase, restores the register defaults and
// drops every item in flight.
// ----------------------------------------------------------------------------
// uv_sine_displacement
// Sine-wave animation of texture coordinates driven by a time phase register.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sine_displacement #(
  parameter int unsigned MAX_VERTICES    = 4096,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [uvsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [uvsd_pkg::REG_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 mode,
  input  wire logic [uvsd_pkg::IDX_W-1:0]           vertex_index,
  input  wire logic signed [uvsd_pkg::COORD_W-1:0]  base_u,
  input  wire logic signed [uvsd_pkg::COORD_W-1:0]  base_v,
  input  wire logic [uvsd_pkg::DELTA_W-1:0]         delta_ms,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [uvsd_pkg::IDX_W-1:0]                out_index,
  output logic signed [uvsd_pkg::COORD_W-1:0]       out_u,
  output logic signed [uvsd_pkg::COORD_W-1:0]       out_v
);

  uvsd_pkg::cfg_t  cfg;
  uvsd_pkg::vert_t push_item;
  uvsd_pkg::vert_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_amp      <= uvsd_pkg::X_AMP_RESET;
      cfg.y_amp      <= uvsd_pkg::Y_AMP_RESET;
      cfg.rate       <= uvsd_pkg::RATE_RESET;
      cfg.per_vertex <= uvsd_pkg::PER_VERTEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        uvsd_pkg::REG_X_AMP:      cfg.x_amp      <= cfg_data;
        uvsd_pkg::REG_Y_AMP:      cfg.y_amp      <= cfg_data;
        uvsd_pkg::REG_RATE:       cfg.rate       <= cfg_data;
        uvsd_pkg::REG_PER_VERTEX: cfg.per_vertex <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  uvsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .vertex_index (vertex_index),
    .base_u       (base_u),
    .base_v       (base_v),
    .delta_ms     (delta_ms),
    .cfg          (cfg),
    .full         (full),
    .push         (push),
    .push_item    (push_item)
  );

  uvsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  uvsd_back #(
    .MAX_VERTICES    (MAX_VERTICES),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .out_u     (out_u),
    .out_v     (out_v)
  );

endmodule

`default_nettype wire
